[design/tsl_pkg.sv]
package tsl_pkg;

    localparam int KW_COUNT = 19;
    localparam int KW_MAX = 11;
    localparam int OP_COUNT = 9;
    localparam int QUEUE_DEPTH = 4;

    // Scanner mode between decisions.
    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUM,
        MODE_STR
    } mode_t;

    localparam logic [5:0] K_ERROR = 6'd0;
    localparam logic [5:0] K_T = 6'd19;
    localparam logic [5:0] K_IDENT = 6'd20;
    localparam logic [5:0] K_INT = 6'd21;
    localparam logic [5:0] K_DOUBLE = 6'd22;
    localparam logic [5:0] K_STRING = 6'd23;
    localparam logic [5:0] K_NEQ = 6'd24;
    localparam logic [5:0] K_GE = 6'd25;
    localparam logic [5:0] K_LE = 6'd26;
    localparam logic [5:0] K_OP_BASE = 6'd27;
    localparam logic [5:0] K_EOF = 6'd36;

    // Keyword text, right-justified: character j of a word of length n
    // sits at bits [(n-1-j)*8 +: 8]. Lower index wins.
    localparam logic [KW_MAX*8-1:0] KW_TEXT [KW_COUNT] = '{
        "dotimes", "return", "loop", "let", "setq", "if", "when", "cond",
        "defvar", "defconstant", "defun", "nil", "logand", "logior",
        "logxor", "lognor", "and", "or", "not"
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd7, 4'd6, 4'd4, 4'd3, 4'd4, 4'd2, 4'd4, 4'd4, 4'd6, 4'd11, 4'd5,
        4'd3, 4'd6, 4'd6, 4'd6, 4'd6, 4'd3, 4'd2, 4'd3
    };
    localparam logic [5:0] KW_KIND [KW_COUNT] = '{
        6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10,
        6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18
    };

    // Single-byte operators, kind K_OP_BASE plus the index.
    localparam logic [7:0] OP_CHAR [OP_COUNT] = '{
        8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3D, 8'h3E, 8'h3C, 8'h28, 8'h29
    };

    typedef struct packed {
        logic [5:0]  token_kind;
        logic        has_text;
        logic [7:0]  text_char;
        logic        token_done;
        logic        lex_error;
        logic [15:0] error_line;
    } result_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

endpackage

[design/tsl_front.sv]
module tsl_front
    import tsl_pkg::*;
#(
    parameter int LOOKAHEAD = 11,
    parameter int LINE_BITS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_res
);

    localparam int CW = $clog2(LOOKAHEAD + 1);
    localparam int EXT_W = (LINE_BITS > 16) ? LINE_BITS : 16;

    logic [LOOKAHEAD*8-1:0] win_reg, win_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    mode_t                  mode_reg, mode_next;
    logic                   dot_reg, dot_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic                   halt_reg, halt_next;
    logic                   drain_reg, drain_next;

    logic [7:0]       pk [LOOKAHEAD];
    logic [7:0]       c;
    logic             have;
    logic             work;
    logic             step;
    logic             accept;
    logic             emit;
    logic             fail;
    logic             eof;
    logic [CW-1:0]    pop_n;
    mode_t            mode_d;
    logic             dot_d;
    result_t          res;
    logic             kw_hit;
    logic [5:0]       kw_kind;
    logic [3:0]       kw_len;
    logic             kw_ok;
    logic [EXT_W-1:0] line_ext;
    logic [15:0]      line_sat;
    logic             nl_head;

    always_comb begin
        for (int i = 0; i < LOOKAHEAD; i++) begin
            pk[i] = (CW'(i) < cnt_reg) ? win_reg[i*8 +: 8] : 8'h00;
        end
    end

    assign c = pk[0];
    assign have = cnt_reg != '0;
    assign line_ext = EXT_W'(line_reg);
    assign line_sat = (line_ext > EXT_W'(16'hFFFF)) ? 16'hFFFF : line_ext[15:0];

    // Keyword prefix search; the lowest matching entry wins.
    always_comb begin
        kw_hit = 1'b0;
        kw_kind = '0;
        kw_len = '0;
        kw_ok = 1'b0;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            kw_ok = 1'b1;
            for (int j = 0; j < KW_MAX; j++) begin
                if (4'(j) < KW_LEN[k] &&
                    pk[j] != KW_TEXT[k][(32'(KW_LEN[k]) - 1 - j) * 8 +: 8]) begin
                    kw_ok = 1'b0;
                end
            end
            if (kw_ok) begin
                kw_hit = 1'b1;
                kw_kind = KW_KIND[k];
                kw_len = KW_LEN[k];
            end
        end
    end

    assign work = drain_reg || (cnt_reg == CW'(LOOKAHEAD) && !halt_reg);
    assign in_ready = !work;
    assign accept = in_valid && in_ready;
    assign step = work && out_ready;
    assign out_valid = work && emit;
    assign out_res = res;

    // One decision at the head of the window.
    always_comb begin
        emit = 1'b0;
        fail = 1'b0;
        eof = 1'b0;
        pop_n = '0;
        mode_d = mode_reg;
        dot_d = dot_reg;
        res = '0;
        case (mode_reg)
            MODE_IDENT: begin
                res.token_kind = K_IDENT;
                emit = 1'b1;
                if (have && (is_alpha(c) || is_digit(c) || c == 8'h5F || c == 8'h2D)) begin
                    res.has_text = 1'b1;
                    res.text_char = c;
                    pop_n = CW'(1);
                end else begin
                    res.token_done = 1'b1;
                    mode_d = MODE_IDLE;
                end
            end
            MODE_NUM: begin
                if (have && is_alpha(c)) begin
                    fail = 1'b1;
                end else if (have && (is_digit(c) || c == 8'h2E)) begin
                    dot_d = dot_reg || c == 8'h2E;
                    emit = 1'b1;
                    res.token_kind = dot_d ? K_DOUBLE : K_INT;
                    res.has_text = 1'b1;
                    res.text_char = c;
                    pop_n = CW'(1);
                end else begin
                    emit = 1'b1;
                    res.token_kind = dot_reg ? K_DOUBLE : K_INT;
                    res.token_done = 1'b1;
                    mode_d = MODE_IDLE;
                    dot_d = 1'b0;
                end
            end
            MODE_STR: begin
                emit = 1'b1;
                res.token_kind = K_STRING;
                pop_n = have ? CW'(1) : '0;
                if (have && c != 8'h22) begin
                    res.has_text = 1'b1;
                    res.text_char = c;
                end else begin
                    res.token_done = 1'b1;
                    mode_d = MODE_IDLE;
                end
            end
            default: begin
                res.token_done = 1'b1;
                if (drain_reg && !have) begin
                    eof = 1'b1;
                    emit = 1'b1;
                    res.token_kind = K_EOF;
                end else if (is_space(c)) begin
                    pop_n = CW'(1);
                end else if (kw_hit) begin
                    emit = 1'b1;
                    res.token_kind = kw_kind;
                    pop_n = CW'(kw_len);
                end else if (c == 8'h74 && (pk[1] == 8'h20 || pk[1] == 8'h29)) begin
                    emit = 1'b1;
                    res.token_kind = K_T;
                    pop_n = CW'(1);
                end else if (is_alpha(c)) begin
                    mode_d = MODE_IDENT;
                end else if (is_digit(c)) begin
                    mode_d = MODE_NUM;
                    dot_d = 1'b0;
                end else if (c == 8'h22) begin
                    mode_d = MODE_STR;
                    pop_n = CW'(1);
                end else if (pk[1] == 8'h3D && (c == 8'h2F || c == 8'h3E || c == 8'h3C)) begin
                    emit = 1'b1;
                    res.token_kind = (c == 8'h2F) ? K_NEQ : (c == 8'h3E) ? K_GE : K_LE;
                    pop_n = CW'(2);
                end else begin
                    fail = 1'b1;
                    for (int i = 0; i < OP_COUNT; i++) begin
                        if (c == OP_CHAR[i]) begin
                            fail = 1'b0;
                            emit = 1'b1;
                            res.token_kind = K_OP_BASE + 6'(i);
                            pop_n = CW'(1);
                        end
                    end
                end
            end
        endcase
        if (fail) begin
            emit = 1'b1;
            res = '0;
            res.token_kind = K_ERROR;
            res.text_char = c;
            res.lex_error = 1'b1;
            res.error_line = line_sat;
        end
    end

    assign nl_head = (pop_n != '0) && (c == 8'h0A);

    always_comb begin
        win_next = win_reg;
        cnt_next = cnt_reg;
        mode_next = mode_reg;
        dot_next = dot_reg;
        line_next = line_reg;
        halt_next = halt_reg;
        drain_next = drain_reg;
        if (accept) begin
            if (halt_reg) begin
                if (in_last) begin
                    cnt_next = '0;
                    mode_next = MODE_IDLE;
                    dot_next = 1'b0;
                    line_next = '0;
                    halt_next = 1'b0;
                end
            end else begin
                for (int i = 0; i < LOOKAHEAD; i++) begin
                    if (CW'(i) == cnt_reg) begin
                        win_next[i*8 +: 8] = in_byte;
                    end
                end
                cnt_next = cnt_reg + CW'(1);
                drain_next = in_last;
            end
        end else if (step) begin
            if (eof || (fail && drain_reg)) begin
                cnt_next = '0;
                mode_next = MODE_IDLE;
                dot_next = 1'b0;
                line_next = '0;
                halt_next = 1'b0;
                drain_next = 1'b0;
            end else if (fail) begin
                cnt_next = '0;
                mode_next = MODE_IDLE;
                dot_next = 1'b0;
                halt_next = 1'b1;
            end else begin
                win_next = win_reg >> {pop_n, 3'b000};
                cnt_next = cnt_reg - pop_n;
                mode_next = mode_d;
                dot_next = dot_d;
                if (nl_head && line_reg != '1) begin
                    line_next = line_reg + LINE_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
        if (!aresetn) begin
            cnt_reg <= '0;
            mode_reg <= MODE_IDLE;
            dot_reg <= 1'b0;
            line_reg <= '0;
            halt_reg <= 1'b0;
            drain_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            mode_reg <= mode_next;
            dot_reg <= dot_next;
            line_reg <= line_next;
            halt_reg <= halt_next;
            drain_reg <= drain_next;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(LOOKAHEAD))
        else $error("window count beyond lookahead depth");

    a_halt_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg |-> (cnt_reg == '0 && mode_reg == MODE_IDLE && !drain_reg))
        else $error("halted scanner still holds text");

    a_fail_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && fail && !drain_reg) |=> (halt_reg && cnt_reg == '0))
        else $error("error result did not halt the scanner");

    a_eof_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && eof) |=> (!drain_reg && line_reg == '0 && cnt_reg == '0))
        else $error("end of text left state behind");

endmodule

[design/tsl_queue.sv]
module tsl_queue
    import tsl_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_res,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    result_t         mem [QUEUE_DEPTH];
    logic [PW-1:0]   wr_reg, rd_reg;
    logic [PW:0]     cnt_reg, cnt_next;
    logic            push;
    logic            pop;

    assign in_ready = cnt_reg != (PW + 1)'(QUEUE_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_res = mem[rd_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + (PW + 1)'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - (PW + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= in_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + PW'(1);
            end
            if (pop) begin
                rd_reg <= rd_reg + PW'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

[design/sexpr_token_lexer_core.sv]
// S-expression token lexer.
// The slave channel takes source text one byte per transfer in s_tdata[7:0],
// with s_tlast high on the final byte of a text. The master channel gives one
// token result per transfer. Keywords and operators give a single result;
// identifiers, numbers and strings give one result per text byte and then a
// closing result with m_tlast high. An illegal byte, or a letter inside a
// number, gives an error result with the line number; the rest of that text is
// then ignored up to and including its final byte. End of text flushes the
// window and gives an eof result.
// The front keeps a LOOKAHEAD-byte window and makes one decision per cycle at
// its head while the window is full or the text is draining and the queue
// has room; a whole keyword is taken in one decision. The slave channel is
// not ready while the front decides, so byte transfers and decisions never
// share a cycle. Each result goes through a four-entry queue that sits
// between front and output, so a stalled receiver only stops the front when
// the queue fills, and no result is ever dropped.
// Reset (aresetn low at a clock edge) empties the window and queue and sets
// the line count to zero; no clearing pass is needed.
module sexpr_token_lexer_core
    import tsl_pkg::*;
#(
    parameter int LOOKAHEAD = 11,
    parameter int LINE_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [7:0] text_byte
    input  logic        s_tlast,  // text_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // [5:0] token_kind, [13:6] text_char,
                                  // [29:14] error_line, [31:30] zero
    output logic [1:0]  m_tuser,  // [0] has_text, [1] lex_error
    output logic        m_tlast   // token_done
);

    logic    fr_valid;
    logic    fr_ready;
    result_t fr_res;
    result_t q_res;

    // Front: window, classification and the scanner state.
    tsl_front #(
        .LOOKAHEAD(LOOKAHEAD),
        .LINE_BITS(LINE_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .out_valid(fr_valid),
        .out_ready(fr_ready),
        .out_res  (fr_res)
    );

    // Back: result queue that drives the master channel.
    tsl_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (fr_valid),
        .in_ready (fr_ready),
        .in_res   (fr_res),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_res  (q_res)
    );

    assign m_tdata = {2'b00, q_res.error_line, q_res.text_char, q_res.token_kind};
    assign m_tuser = {q_res.lex_error, q_res.has_text};
    assign m_tlast = q_res.token_done;

endmodule
